// ===== hw/rtl/plp_pkg.sv =====
// plp_pkg: shared constants, word types and the pipeline context record
// for the low-arc projectile solver; no dependencies
package plp_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int DEN_EPS     = 1;
  localparam int VEL_EPS_RAW = ((1 << FRAC_BITS) + 5000) / 10000;
  localparam int VEL_EPS     = VEL_EPS_RAW + ((VEL_EPS_RAW == 0) ? 1 : 0);

  localparam logic [30:0] GRAVITY_RESET = 31'd642908;

  localparam int SQ_STAGES  = 64;   // one root bit per stage
  localparam int DIV_STAGES = 128;  // one quotient bit per stage
  localparam int QLO_BITS   = 64;   // quotient bits kept, upper ones saturate
  localparam int MUL_LANES  = 4;

  typedef struct packed {
    logic signed [31:0] from_x;
    logic signed [31:0] from_y;
    logic signed [31:0] from_z;
    logic signed [31:0] to_x;
    logic signed [31:0] to_y;
    logic signed [31:0] to_z;
    logic        [30:0] launch_speed;
  } in_word_t;

  typedef struct packed {
    logic               reachable;
    logic        [30:0] flight_time;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } out_word_t;

  // everything a solve still needs while it travels down the pipe
  typedef struct packed {
    logic        dx_neg;
    logic        dz_neg;
    logic        h_neg;
    logic [32:0] adx;
    logic [32:0] adz;
    logic [32:0] ah;
    logic [30:0] spd;
    logic [30:0] grav;
    logic [32:0] gnd_d;
    logic [61:0] s2;
    logic [63:0] gd;
    logic [63:0] gah;
    logic        unr;
    logic        num_neg;
    logic [63:0] anum;
    logic [63:0] den;
    logic [63:0] hyp;
    logic [63:0] vh;
    logic [63:0] avy;
  } ctx_t;

endpackage

// ===== hw/rtl/plp_mul.sv =====
// plp_mul: four-lane 64x64 multiplier, 32-bit partial products then sum
// depends on plp_pkg
module plp_mul (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   vld_i,
  input  plp_pkg::ctx_t                          ctx_i,
  input  logic [plp_pkg::MUL_LANES-1:0][63:0]    a_i,
  input  logic [plp_pkg::MUL_LANES-1:0][63:0]    b_i,
  output logic                                   vld_o,
  output plp_pkg::ctx_t                          ctx_o,
  output logic [plp_pkg::MUL_LANES-1:0][127:0]   p_o
);
  import plp_pkg::*;

  logic [MUL_LANES-1:0][3:0][63:0] pp_r;
  logic [MUL_LANES-1:0][127:0]     p_r;
  logic                            vld1_r, vld2_r;
  ctx_t                            ctx1_r, ctx2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx1_r <= ctx_i;
      ctx2_r <= ctx1_r;
      for (int l = 0; l < MUL_LANES; l++) begin
        pp_r[l][0] <= 64'(a_i[l][31:0])  * 64'(b_i[l][31:0]);
        pp_r[l][1] <= 64'(a_i[l][31:0])  * 64'(b_i[l][63:32]);
        pp_r[l][2] <= 64'(a_i[l][63:32]) * 64'(b_i[l][31:0]);
        pp_r[l][3] <= 64'(a_i[l][63:32]) * 64'(b_i[l][63:32]);
        p_r[l]     <= {pp_r[l][3], pp_r[l][0]}
                    + {32'b0, pp_r[l][1], 32'b0}
                    + {32'b0, pp_r[l][2], 32'b0};
      end
    end
  end

  assign vld_o = vld2_r;
  assign ctx_o = ctx2_r;
  assign p_o   = p_r;

endmodule

// ===== hw/rtl/plp_sqrt.sv =====
// plp_sqrt: floor square root of a 128-bit value, one root bit per stage
// depends on plp_pkg
module plp_sqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_i,
  input  plp_pkg::ctx_t  ctx_i,
  input  logic [127:0]   rad_i,
  output logic           vld_o,
  output plp_pkg::ctx_t  ctx_o,
  output logic [63:0]    root_o
);
  import plp_pkg::*;

  logic [127:0] rad_r  [SQ_STAGES];
  logic [65:0]  rem_r  [SQ_STAGES];
  logic [63:0]  root_r [SQ_STAGES];
  ctx_t         ctx_r  [SQ_STAGES];
  logic         vld_r  [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_st
    logic [127:0] rad_in;
    logic [65:0]  rem_in;
    logic [63:0]  root_in;
    ctx_t         ctx_in;
    logic         vld_in;
    logic [65:0]  acc;
    logic [65:0]  trial;
    logic         ge;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign ctx_in  = ctx_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rad_in  = rad_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign ctx_in  = ctx_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    // remainder stays below 2*root+1, so its low 64 bits carry it
    assign acc   = {rem_in[63:0], rad_in[127:126]};
    assign trial = {root_in, 2'b01};
    assign ge    = (acc >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= {rad_in[125:0], 2'b00};
        rem_r[k]  <= ge ? (acc - trial) : acc;
        root_r[k] <= {root_in[62:0], ge};
        ctx_r[k]  <= ctx_in;
      end
    end
  end

  assign vld_o  = vld_r[SQ_STAGES-1];
  assign ctx_o  = ctx_r[SQ_STAGES-1];
  assign root_o = root_r[SQ_STAGES-1];

endmodule

// ===== hw/rtl/plp_div.sv =====
// plp_div: 128 by 64 bit restoring divider, one quotient bit per stage,
// quotient saturates at 2^64-1; depends on plp_pkg
module plp_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_i,
  input  plp_pkg::ctx_t  ctx_i,
  input  logic [127:0]   num_i,
  input  logic [63:0]    den_i,
  output logic           vld_o,
  output plp_pkg::ctx_t  ctx_o,
  output logic [63:0]    quo_o
);
  import plp_pkg::*;

  logic [127:0] num_r [DIV_STAGES];
  logic [63:0]  den_r [DIV_STAGES];
  logic [63:0]  rem_r [DIV_STAGES];
  logic [63:0]  quo_r [DIV_STAGES];
  logic         sat_r [DIV_STAGES];
  ctx_t         ctx_r [DIV_STAGES];
  logic         vld_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_st
    localparam logic HI_STEP = (k < DIV_STAGES - QLO_BITS);
    logic [127:0] num_in;
    logic [63:0]  den_in;
    logic [63:0]  rem_in;
    logic [63:0]  quo_in;
    logic         sat_in;
    ctx_t         ctx_in;
    logic         vld_in;
    logic [64:0]  acc;
    logic         ge;

    if (k == 0) begin : g_first
      assign num_in = num_i;
      assign den_in = den_i;
      assign rem_in = '0;
      assign quo_in = '0;
      assign sat_in = 1'b0;
      assign ctx_in = ctx_i;
      assign vld_in = vld_i;
    end else begin : g_next
      assign num_in = num_r[k-1];
      assign den_in = den_r[k-1];
      assign rem_in = rem_r[k-1];
      assign quo_in = quo_r[k-1];
      assign sat_in = sat_r[k-1];
      assign ctx_in = ctx_r[k-1];
      assign vld_in = vld_r[k-1];
    end

    assign acc = {rem_in, num_in[127]};
    assign ge  = (acc >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k] <= {num_in[126:0], 1'b0};
        den_r[k] <= den_in;
        rem_r[k] <= ge ? 64'(acc - {1'b0, den_in}) : acc[63:0];
        quo_r[k] <= {quo_in[62:0], ge};
        sat_r[k] <= sat_in | (ge & HI_STEP);
        ctx_r[k] <= ctx_in;
      end
    end
  end

  assign vld_o = vld_r[DIV_STAGES-1];
  assign ctx_o = ctx_r[DIV_STAGES-1];
  assign quo_o = sat_r[DIV_STAGES-1] ? '1 : quo_r[DIV_STAGES-1];

endmodule

// ===== hw/rtl/projectile_low_arc_solver.sv =====
// projectile_low_arc_solver: top level of the low-arc launch solver
// depends on plp_pkg, plp_mul, plp_sqrt and plp_div
//
//   port group  dir  handshake            word
//   in_*        in   in_valid/in_ready    in_word  (points and speed)
//   out_*       out  out_valid/out_ready  out_word (flag, time, velocity)
//   cfg_*       in   cfg_we, no wait      cfg_wdata (gravity, Q15.16)
//
// one word enters per cycle while in_ready is high; from the edge that accepts
// a word to out_valid the solve passes three 64-stage root chains and two
// 128-stage divide chains in series, one bit per stage
// reset clears every valid bit and loads gravity with 9.81
// a stall at the output freezes the whole pipe, bubbles included, so nothing
// is dropped or repeated; in_ready is low only while a result waits
module projectile_low_arc_solver (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  plp_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output plp_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [30:0]        cfg_wdata
);
  import plp_pkg::*;

  // sign and magnitude to a saturated signed 32-bit pattern
  function automatic logic [31:0] pack_signed(input logic neg, input logic [63:0] m);
    logic [31:0] r;
    if (neg) begin
      r = (m > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - m);
    end else begin
      r = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    end
    return r;
  endfunction

  logic        en;
  logic [30:0] grav_r;

  // input stage
  logic signed [32:0] dx, dz, dh;
  ctx_t               a_ctx_nxt, a_ctx_r;
  logic               a_vld_r;

  // distance
  logic [MUL_LANES-1:0][63:0]  m1_a, m1_b;
  logic [MUL_LANES-1:0][127:0] m1_p;
  ctx_t                        m1_ctx;
  logic                        m1_vld;
  logic [127:0]                b_sum_r;
  ctx_t                        b_ctx_r;
  logic                        b_vld_r;
  logic [63:0]                 sq1_root;
  ctx_t                        sq1_ctx, c_ctx;
  logic                        sq1_vld;

  // discriminant
  logic [MUL_LANES-1:0][63:0]  m2_a, m2_b;
  logic [MUL_LANES-1:0][127:0] m2_p;
  ctx_t                        m2_ctx;
  logic                        m2_vld;
  ctx_t                        cs_ctx_nxt, cs_ctx_r;
  logic                        cs_vld_r;
  logic [MUL_LANES-1:0][63:0]  m3_a, m3_b;
  logic [MUL_LANES-1:0][127:0] m3_p;
  ctx_t                        m3_ctx;
  logic                        m3_vld;
  logic [127:0]                t2;
  logic [127:0]                d_p_r, d_n_r;
  ctx_t                        d_ctx_r;
  logic                        d_vld_r;
  logic [127:0]                e_rad_r;
  ctx_t                        e_ctx_nxt, e_ctx_r;
  logic                        e_vld_r;
  logic [63:0]                 sq2_root;
  ctx_t                        sq2_ctx;
  logic                        sq2_vld;

  // tangent and hypotenuse
  ctx_t                        f_ctx_nxt, f_ctx_r;
  logic                        f_vld_r;
  logic [MUL_LANES-1:0][63:0]  m4_a, m4_b;
  logic [MUL_LANES-1:0][127:0] m4_p;
  ctx_t                        m4_ctx;
  logic                        m4_vld;
  logic [127:0]                g_rad_r;
  ctx_t                        g_ctx_r;
  logic                        g_vld_r;
  logic [63:0]                 sq3_root;
  ctx_t                        sq3_ctx, sq3_ctx_hyp;
  logic                        sq3_vld;

  // speed split
  logic [MUL_LANES-1:0][63:0]  m5_a, m5_b;
  logic [MUL_LANES-1:0][127:0] m5_p;
  ctx_t                        m5_ctx;
  logic                        m5_vld;
  logic [63:0]                 dv1_q, dv2_q;
  ctx_t                        dv1_ctx;
  logic                        dv1_vld;
  ctx_t                        h_ctx_nxt, h_ctx_r;
  logic                        h_vld_r;

  // time and ground components
  logic [MUL_LANES-1:0][63:0]  m6_a, m6_b;
  logic [MUL_LANES-1:0][127:0] m6_p;
  ctx_t                        m6_ctx;
  logic                        m6_vld;
  logic [63:0]                 dv3_q, dv4_q, dv5_q;
  ctx_t                        dv3_ctx;
  logic                        dv3_vld;

  // output register
  out_word_t                   out_nxt, out_r;
  logic                        out_vld_r;
  logic [63:0]                 vx_m, vz_m;
  logic                        vx_neg, vz_neg;

  // whole pipe moves whenever the output slot is free or being emptied
  assign en       = !out_vld_r || out_ready;
  assign in_ready = en;

  // gravity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= GRAVITY_RESET;
    end else if (cfg_we) begin
      grav_r <= cfg_wdata;
    end
  end

  // input stage: differences and magnitudes
  assign dx = 33'(in_word.to_x) - 33'(in_word.from_x);
  assign dh = 33'(in_word.to_y) - 33'(in_word.from_y);
  assign dz = 33'(in_word.to_z) - 33'(in_word.from_z);

  always_comb begin
    a_ctx_nxt        = '0;
    a_ctx_nxt.dx_neg = dx[32];
    a_ctx_nxt.dz_neg = dz[32];
    a_ctx_nxt.h_neg  = dh[32];
    a_ctx_nxt.adx    = dx[32] ? 33'(-dx) : 33'(dx);
    a_ctx_nxt.adz    = dz[32] ? 33'(-dz) : 33'(dz);
    a_ctx_nxt.ah     = dh[32] ? 33'(-dh) : 33'(dh);
    a_ctx_nxt.spd    = in_word.launch_speed;
    a_ctx_nxt.grav   = grav_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      cs_vld_r  <= 1'b0;
      d_vld_r   <= 1'b0;
      e_vld_r   <= 1'b0;
      f_vld_r   <= 1'b0;
      g_vld_r   <= 1'b0;
      h_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r   <= in_valid;
      b_vld_r   <= m1_vld;
      cs_vld_r  <= m2_vld;
      d_vld_r   <= m3_vld;
      e_vld_r   <= d_vld_r;
      f_vld_r   <= sq2_vld;
      g_vld_r   <= m4_vld;
      h_vld_r   <= dv1_vld;
      out_vld_r <= dv3_vld;
    end
  end

  // ground distance squared
  always_comb begin
    m1_a    = '0;
    m1_b    = '0;
    m1_a[0] = 64'(a_ctx_r.adx);
    m1_b[0] = 64'(a_ctx_r.adx);
    m1_a[1] = 64'(a_ctx_r.adz);
    m1_b[1] = 64'(a_ctx_r.adz);
  end

  plp_mul u_mul1 (
    .clk, .rst_n, .en,
    .vld_i(a_vld_r), .ctx_i(a_ctx_r), .a_i(m1_a), .b_i(m1_b),
    .vld_o(m1_vld), .ctx_o(m1_ctx), .p_o(m1_p)
  );

  plp_sqrt u_sqrt_dist (
    .clk, .rst_n, .en,
    .vld_i(b_vld_r), .ctx_i(b_ctx_r), .rad_i(b_sum_r),
    .vld_o(sq1_vld), .ctx_o(sq1_ctx), .root_o(sq1_root)
  );

  always_comb begin
    c_ctx       = sq1_ctx;
    c_ctx.gnd_d = sq1_root[32:0];
  end

  // s^2, g*d and g*|h|, the last two wrap at 64 bits
  always_comb begin
    m2_a    = '0;
    m2_b    = '0;
    m2_a[0] = 64'(c_ctx.spd);
    m2_b[0] = 64'(c_ctx.spd);
    m2_a[1] = 64'(c_ctx.grav);
    m2_b[1] = 64'(c_ctx.gnd_d);
    m2_a[2] = 64'(c_ctx.grav);
    m2_b[2] = 64'(c_ctx.ah);
  end

  plp_mul u_mul2 (
    .clk, .rst_n, .en,
    .vld_i(sq1_vld), .ctx_i(c_ctx), .a_i(m2_a), .b_i(m2_b),
    .vld_o(m2_vld), .ctx_o(m2_ctx), .p_o(m2_p)
  );

  always_comb begin
    cs_ctx_nxt     = m2_ctx;
    cs_ctx_nxt.s2  = m2_p[0][61:0];
    cs_ctx_nxt.gd  = m2_p[1][63:0];
    cs_ctx_nxt.gah = m2_p[2][63:0];
  end

  // s^4, (g*d)^2 and g*|h|*s^2
  always_comb begin
    m3_a    = '0;
    m3_b    = '0;
    m3_a[0] = 64'(cs_ctx_r.s2);
    m3_b[0] = 64'(cs_ctx_r.s2);
    m3_a[1] = cs_ctx_r.gd;
    m3_b[1] = cs_ctx_r.gd;
    m3_a[2] = cs_ctx_r.gah;
    m3_b[2] = 64'(cs_ctx_r.s2);
  end

  plp_mul u_mul3 (
    .clk, .rst_n, .en,
    .vld_i(cs_vld_r), .ctx_i(cs_ctx_r), .a_i(m3_a), .b_i(m3_b),
    .vld_o(m3_vld), .ctx_o(m3_ctx), .p_o(m3_p)
  );

  // height term lands on whichever side keeps both sums non-negative
  assign t2 = {m3_p[2][126:0], 1'b0};

  // negative discriminant marks the solve unreachable
  always_comb begin
    e_ctx_nxt     = d_ctx_r;
    e_ctx_nxt.unr = (d_p_r < d_n_r);
  end

  plp_sqrt u_sqrt_disc (
    .clk, .rst_n, .en,
    .vld_i(e_vld_r), .ctx_i(e_ctx_r), .rad_i(e_rad_r),
    .vld_o(sq2_vld), .ctx_o(sq2_ctx), .root_o(sq2_root)
  );

  // low arc tangent numerator and denominator
  always_comb begin
    f_ctx_nxt         = sq2_ctx;
    f_ctx_nxt.num_neg = (sq2_root > 64'(sq2_ctx.s2));
    f_ctx_nxt.anum    = f_ctx_nxt.num_neg ? (sq2_root - 64'(sq2_ctx.s2))
                                          : (64'(sq2_ctx.s2) - sq2_root);
    f_ctx_nxt.den     = sq2_ctx.gd + (64'(DEN_EPS) << FRAC_BITS);
  end

  always_comb begin
    m4_a    = '0;
    m4_b    = '0;
    m4_a[0] = f_ctx_r.anum;
    m4_b[0] = f_ctx_r.anum;
    m4_a[1] = f_ctx_r.den;
    m4_b[1] = f_ctx_r.den;
  end

  plp_mul u_mul4 (
    .clk, .rst_n, .en,
    .vld_i(f_vld_r), .ctx_i(f_ctx_r), .a_i(m4_a), .b_i(m4_b),
    .vld_o(m4_vld), .ctx_o(m4_ctx), .p_o(m4_p)
  );

  plp_sqrt u_sqrt_hyp (
    .clk, .rst_n, .en,
    .vld_i(g_vld_r), .ctx_i(g_ctx_r), .rad_i(g_rad_r),
    .vld_o(sq3_vld), .ctx_o(sq3_ctx), .root_o(sq3_root)
  );

  always_comb begin
    sq3_ctx_hyp     = sq3_ctx;
    sq3_ctx_hyp.hyp = sq3_root;
  end

  // s*den and s*|num| over the hypotenuse give the two speed parts
  always_comb begin
    m5_a    = '0;
    m5_b    = '0;
    m5_a[0] = 64'(sq3_ctx_hyp.spd);
    m5_b[0] = sq3_ctx_hyp.den;
    m5_a[1] = 64'(sq3_ctx_hyp.spd);
    m5_b[1] = sq3_ctx_hyp.anum;
  end

  plp_mul u_mul5 (
    .clk, .rst_n, .en,
    .vld_i(sq3_vld), .ctx_i(sq3_ctx_hyp), .a_i(m5_a), .b_i(m5_b),
    .vld_o(m5_vld), .ctx_o(m5_ctx), .p_o(m5_p)
  );

  plp_div u_div_vh (
    .clk, .rst_n, .en,
    .vld_i(m5_vld), .ctx_i(m5_ctx), .num_i(m5_p[0]), .den_i(m5_ctx.hyp),
    .vld_o(dv1_vld), .ctx_o(dv1_ctx), .quo_o(dv1_q)
  );

  plp_div u_div_vy (
    .clk, .rst_n, .en,
    .vld_i(m5_vld), .ctx_i('0), .num_i(m5_p[1]), .den_i(m5_ctx.hyp),
    .vld_o(), .ctx_o(), .quo_o(dv2_q)
  );

  always_comb begin
    h_ctx_nxt     = dv1_ctx;
    h_ctx_nxt.vh  = dv1_q;
    h_ctx_nxt.avy = dv2_q;
    h_ctx_nxt.unr = dv1_ctx.unr || (dv1_q < 64'(VEL_EPS));
  end

  // ground components before the divide by distance, wrapping at 64 bits
  always_comb begin
    m6_a    = '0;
    m6_b    = '0;
    m6_a[0] = 64'(h_ctx_r.adx);
    m6_b[0] = h_ctx_r.vh;
    m6_a[1] = 64'(h_ctx_r.adz);
    m6_b[1] = h_ctx_r.vh;
  end

  plp_mul u_mul6 (
    .clk, .rst_n, .en,
    .vld_i(h_vld_r), .ctx_i(h_ctx_r), .a_i(m6_a), .b_i(m6_b),
    .vld_o(m6_vld), .ctx_o(m6_ctx), .p_o(m6_p)
  );

  plp_div u_div_tof (
    .clk, .rst_n, .en,
    .vld_i(m6_vld), .ctx_i(m6_ctx),
    .num_i(128'(m6_ctx.gnd_d) << FRAC_BITS), .den_i(m6_ctx.vh),
    .vld_o(dv3_vld), .ctx_o(dv3_ctx), .quo_o(dv3_q)
  );

  plp_div u_div_vx (
    .clk, .rst_n, .en,
    .vld_i(m6_vld), .ctx_i('0),
    .num_i(128'(m6_p[0][63:0])), .den_i(64'(m6_ctx.gnd_d)),
    .vld_o(), .ctx_o(), .quo_o(dv4_q)
  );

  plp_div u_div_vz (
    .clk, .rst_n, .en,
    .vld_i(m6_vld), .ctx_i('0),
    .num_i(128'(m6_p[1][63:0])), .den_i(64'(m6_ctx.gnd_d)),
    .vld_o(), .ctx_o(), .quo_o(dv5_q)
  );

  // result assembly; straight up or down falls back to the forward vector
  always_comb begin
    if (64'(dv3_ctx.gnd_d) > 64'(VEL_EPS)) begin
      vx_m   = dv4_q;
      vz_m   = dv5_q;
      vx_neg = dv3_ctx.dx_neg;
      vz_neg = dv3_ctx.dz_neg;
    end else begin
      vx_m   = '0;
      vz_m   = dv3_ctx.vh;
      vx_neg = 1'b0;
      vz_neg = 1'b1;
    end
    out_nxt = '0;
    if (!dv3_ctx.unr) begin
      out_nxt.reachable   = 1'b1;
      out_nxt.flight_time = (dv3_q > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : dv3_q[30:0];
      out_nxt.vel_x       = pack_signed(vx_neg, vx_m);
      out_nxt.vel_y       = pack_signed(dv3_ctx.num_neg, dv3_ctx.avy);
      out_nxt.vel_z       = pack_signed(vz_neg, vz_m);
    end
  end

  // payload registers between the units
  always_ff @(posedge clk) begin
    if (en) begin
      a_ctx_r         <= a_ctx_nxt;
      b_sum_r         <= m1_p[0] + m1_p[1];
      b_ctx_r         <= m1_ctx;
      cs_ctx_r        <= cs_ctx_nxt;
      d_p_r           <= m3_ctx.h_neg ? (m3_p[0] + t2) : m3_p[0];
      d_n_r           <= m3_ctx.h_neg ? m3_p[1] : (m3_p[1] + t2);
      d_ctx_r         <= m3_ctx;
      e_rad_r         <= d_p_r - d_n_r;
      e_ctx_r         <= e_ctx_nxt;
      f_ctx_r         <= f_ctx_nxt;
      g_rad_r         <= m4_p[0] + m4_p[1];
      g_ctx_r         <= m4_ctx;
      h_ctx_r         <= h_ctx_nxt;
      out_r           <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_r;

  // an unreachable result carries no time and no velocity
  a_unreach_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.reachable) |->
      (out_word.flight_time == 31'd0 && out_word.vel_x == 32'sd0 &&
       out_word.vel_y == 32'sd0 && out_word.vel_z == 32'sd0))
    else $error("unreachable result with non-zero fields");

  // input is refused only while a finished result is held
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input refused without an output stall");

  // a held result stays in place over a stall
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
    else $error("held result changed during stall");

  // nothing comes out right after reset
  a_reset_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule

// ===== bench/projectile_low_arc_solver_tb.sv =====
// projectile_low_arc_solver_tb: self-checking bench for the low-arc launch solver
// depends on plp_pkg and projectile_low_arc_solver; a wide-integer predictor
// checks every result word against the solve worked out at acceptance
module projectile_low_arc_solver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import plp_pkg::*;

  localparam int PIPE_LAT = 468;          // acceptance to out_valid
  localparam int IDLE_LIMIT = 20000;      // cycles without any handshake before giving up
  localparam logic [63:0] SPEED_EPS = 64'(VEL_EPS);

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_word_t   in_word = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_word_t  out_word;
  logic       cfg_we = 1'b0;
  logic [30:0] cfg_wdata = '0;

  always #1 clk = ~clk;

  projectile_low_arc_solver dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // bench copy of the gravity register, only changed while nothing is in flight
  logic [30:0] gravity_now = GRAVITY_RESET;

  in_word_t  shots_to_send[$];
  out_word_t solves_due[$];
  int        n_errors = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  int        n_hits = 0;

  // ---------------------------------------------------------------- predictor

  // floor square root of a 128-bit value, one root bit at a time
  function automatic logic [63:0] floor_root(logic [127:0] v);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] sq;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (!(v < sq)) r = c;
    end
    return r;
  endfunction

  // 128 by 64 quotient, saturating at all ones
  function automatic logic [63:0] sat_quot(logic [127:0] num, logic [63:0] dv);
    logic [127:0] q;
    if (dv == 0) return '1;
    q = num / {64'd0, dv};
    return (q[127:64] != 0) ? '1 : q[63:0];
  endfunction

  // signed 32-bit pattern from a sign and a magnitude, saturating
  function automatic logic [31:0] signed_sat(logic neg, logic [63:0] m);
    if (neg) begin
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      return 32'(64'd0 - m);
    end
    if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
    return m[31:0];
  endfunction

  function automatic out_word_t low_arc_solve(in_word_t w, logic [30:0] grav);
    out_word_t    res;
    longint       dx, h, dz;
    logic [63:0]  adx, adz, ah, s, g, d, s2, gd, gah, root, anum, den, hyp, vh, avy;
    logic [63:0]  tof, vx, vz;
    logic [127:0] p, n, t;
    logic         num_neg, vx_neg, vz_neg;
    res = '0;
    dx = longint'(w.to_x) - longint'(w.from_x);
    h  = longint'(w.to_y) - longint'(w.from_y);
    dz = longint'(w.to_z) - longint'(w.from_z);
    adx = (dx < 0) ? 64'(-dx) : 64'(dx);
    adz = (dz < 0) ? 64'(-dz) : 64'(dz);
    ah  = (h < 0) ? 64'(-h) : 64'(h);
    s = 64'(w.launch_speed);
    g = 64'(grav);
    // ground distance and the discriminant terms, all exact
    p = {64'd0, adx} * {64'd0, adx};
    p = p + {64'd0, adz} * {64'd0, adz};
    d = floor_root(p);
    s2 = s * s;
    gd = g * d;
    gah = g * ah;
    p = {64'd0, s2} * {64'd0, s2};
    n = {64'd0, gd} * {64'd0, gd};
    t = {64'd0, gah} * {64'd0, s2};
    t = t + t;
    if (h < 0) p = p + t;
    else n = n + t;
    if (p < n) return res;   // negative discriminant
    root = floor_root(p - n);
    num_neg = root > s2;
    anum = num_neg ? root - s2 : s2 - root;
    den = gd + (64'(DEN_EPS) << FRAC_BITS);
    p = {64'd0, anum} * {64'd0, anum};
    p = p + {64'd0, den} * {64'd0, den};
    hyp = floor_root(p);
    vh  = sat_quot({64'd0, s} * {64'd0, den}, hyp);
    avy = sat_quot({64'd0, s} * {64'd0, anum}, hyp);
    if (vh < SPEED_EPS) return res;   // horizontal speed too small
    tof = (d << FRAC_BITS) / vh;
    if (tof > 64'h7FFF_FFFF) tof = 64'h7FFF_FFFF;
    if (d > SPEED_EPS) begin
      vx = (adx * vh) / d;
      vz = (adz * vh) / d;
      vx_neg = dx < 0;
      vz_neg = dz < 0;
    end else begin
      // straight up or down: fall back to the forward vector
      vx = 0;
      vz = vh;
      vx_neg = 1'b0;
      vz_neg = 1'b1;
    end
    res.reachable   = 1'b1;
    res.flight_time = tof[30:0];
    res.vel_x = signed_sat(vx_neg, vx);
    res.vel_y = signed_sat(num_neg, avy);
    res.vel_z = signed_sat(vz_neg, vz);
    return res;
  endfunction

  // ---------------------------------------------------------------- driver

  // bursts of random length, random gaps between them, sometimes no gaps for a while
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      solves_due.push_back(low_arc_solve(in_word, gravity_now));
      n_sent++;
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
      in_valid <= 1'b1;   // hold the word until it is taken
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else if (shots_to_send.size() > 0) begin
      in_valid <= 1'b1;
      in_word  <= shots_to_send.pop_front();
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- receiver

  // stall pattern of its own, redrawn at the start of every era; some eras never stall
  logic [15:0] stall_pat = '1;
  int          rx_cycle = 0;

  always @(posedge clk) begin
    logic [15:0] pat;
    pat = stall_pat;
    if (rx_cycle % 64 == 0) begin
      case ($urandom_range(0, 3))
        0: pat = '1;
        1: pat = 16'($urandom);
        2: pat = 16'($urandom) | 16'($urandom);
        default: pat = 16'($urandom) & 16'($urandom);
      endcase
      stall_pat <= pat;
    end
    rx_cycle <= rx_cycle + 1;
    out_ready <= pat[rx_cycle % 16];
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (solves_due.size() == 0) begin
        $display("%0t: result word with none expected: %p", $realtime, out_word);
        n_errors++;
      end else begin
        want = solves_due.pop_front();
        n_checked++;
        if (want.reachable) n_hits++;
        if (out_word.reachable !== want.reachable) begin
          $display("%0t: reachable expected %0d actual %0d", $realtime,
                   want.reachable, out_word.reachable);
          n_errors++;
        end
        if (out_word.flight_time !== want.flight_time) begin
          $display("%0t: flight_time expected %0d actual %0d", $realtime,
                   want.flight_time, out_word.flight_time);
          n_errors++;
        end
        if (out_word.vel_x !== want.vel_x) begin
          $display("%0t: vel_x expected %0d actual %0d", $realtime,
                   want.vel_x, out_word.vel_x);
          n_errors++;
        end
        if (out_word.vel_y !== want.vel_y) begin
          $display("%0t: vel_y expected %0d actual %0d", $realtime,
                   want.vel_y, out_word.vel_y);
          n_errors++;
        end
        if (out_word.vel_z !== want.vel_z) begin
          $display("%0t: vel_z expected %0d actual %0d", $realtime,
                   want.vel_z, out_word.vel_z);
          n_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_LIMIT) begin
      $display("timeout: %0d words still expected", solves_due.size());
      $display("projectile_low_arc_solver: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic in_word_t make_shot(logic signed [31:0] fx, logic signed [31:0] fy,
                                         logic signed [31:0] fz, logic signed [31:0] tx,
                                         logic signed [31:0] ty, logic signed [31:0] tz,
                                         logic [30:0] spd);
    in_word_t w;
    w.from_x = fx; w.from_y = fy; w.from_z = fz;
    w.to_x = tx; w.to_y = ty; w.to_z = tz;
    w.launch_speed = spd;
    return w;
  endfunction

  // a point within +-span whole units of a centre, with random fraction bits
  function automatic logic signed [31:0] near(logic signed [31:0] centre, int span);
    return centre + $signed(32'($urandom_range(0, 2 * span) - span) << FRAC_BITS)
           + $signed(32'($urandom_range(0, 65535)));
  endfunction

  function automatic in_word_t random_shot();
    in_word_t w;
    logic signed [31:0] cx, cy, cz;
    int span;
    case ($urandom_range(0, 9))
      0, 1: begin
        // noise across the whole field range
        w = make_shot($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      31'($urandom));
      end
      2: begin
        // nearly vertical or nearly zero ground distance
        cx = $urandom; cy = $urandom_range(0, 1 << 24); cz = $urandom;
        w = make_shot(cx, cy, cz, cx + $signed(32'($urandom_range(0, 15)) - 8),
                      near(cy, 50), cz + $signed(32'($urandom_range(0, 15)) - 8),
                      31'($urandom_range(0, 80 << FRAC_BITS)));
      end
      default: begin
        // well-formed shot at game scale, mostly within reach
        span = ($urandom_range(0, 4) == 0) ? 2000 : 150;
        cx = $signed(32'($urandom)) >>> 2; cy = $signed(32'($urandom)) >>> 4;
        cz = $signed(32'($urandom)) >>> 2;
        w = make_shot(cx, cy, cz, near(cx, span), near(cy, span / 4), near(cz, span),
                      31'($urandom_range(0, 160 << FRAC_BITS)));
      end
    endcase
    return w;
  endfunction

  task automatic drain_and_settle();
    while (shots_to_send.size() > 0 || in_valid || solves_due.size() > 0)
      @(posedge clk);
    repeat (PIPE_LAT + 20) @(posedge clk);
  endtask

  task automatic load_gravity(logic [30:0] g);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
    gravity_now = g;
  endtask

  task automatic queue_directed();
    logic signed [31:0] mx, mn, u;
    mx = 32'sh7FFF_FFFF; mn = 32'sh8000_0000; u = 32'sd1 <<< FRAC_BITS;
    // flat shot, level ground
    shots_to_send.push_back(make_shot(0, 0, 0, 10 * u, 0, 10 * u, 31'(30 << FRAC_BITS)));
    // target straight above, then straight below, then on the launch point
    shots_to_send.push_back(make_shot(0, 0, 0, 0, 5 * u, 0, 31'(20 << FRAC_BITS)));
    shots_to_send.push_back(make_shot(0, 0, 0, 0, -5 * u, 0, 31'(20 << FRAC_BITS)));
    shots_to_send.push_back(make_shot(u, u, u, u, u, u, 31'(10 << FRAC_BITS)));
    // ground distance just at and just past the epsilon
    shots_to_send.push_back(make_shot(0, 0, 0, 7, 0, 0, 31'(10 << FRAC_BITS)));
    shots_to_send.push_back(make_shot(0, 0, 0, 0, 0, -8, 31'(10 << FRAC_BITS)));
    // far out of reach, and zero speed
    shots_to_send.push_back(make_shot(0, 0, 0, 1000 * u, 0, 0, 31'(5 << FRAC_BITS)));
    shots_to_send.push_back(make_shot(0, 0, 0, 3 * u, u, 2 * u, 31'd0));
    // speed at the extremes
    shots_to_send.push_back(make_shot(0, 0, 0, -40 * u, 3 * u, 25 * u, 31'h7FFF_FFFF));
    shots_to_send.push_back(make_shot(0, 0, 0, u, 0, 0, 31'd1));
    // launch from above, target below and behind
    shots_to_send.push_back(make_shot(0, 50 * u, 0, -20 * u, 0, -20 * u,
                                      31'(15 << FRAC_BITS)));
    // coordinates at the extremes of the field
    shots_to_send.push_back(make_shot(mn, mn, mn, mx, mx, mx, 31'h7FFF_FFFF));
    shots_to_send.push_back(make_shot(mx, mx, mx, mn, mn, mn, 31'h7FFF_FFFF));
    shots_to_send.push_back(make_shot(mx, 0, mn, mn, 0, mx, 31'h4000_0000));
    shots_to_send.push_back(make_shot(mn, mx, 0, mn, mn, 0, 31'h7FFF_FFFF));
    shots_to_send.push_back(make_shot(0, mn, 0, 0, mx, 0, 31'h7FFF_FFFF));
    // slow flight, long time of flight
    shots_to_send.push_back(make_shot(0, 0, 0, 30000 * u, 0, 0, 31'h7FFF_FFFF));
    shots_to_send.push_back(make_shot(0, 0, 0, 2 * u, 0, 2 * u, 31'd10));
  endtask

  task automatic queue_random(int count);
    repeat (count) shots_to_send.push_back(random_shot());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset gravity, directed corners first
    queue_directed();
    queue_random(300);
    drain_and_settle();

    // no gravity: flat shots wherever the speed is enough
    load_gravity(31'd0);
    queue_directed();
    queue_random(150);
    drain_and_settle();

    // strongest gravity the register holds
    load_gravity(31'h7FFF_FFFF);
    queue_directed();
    queue_random(150);
    drain_and_settle();

    // a handful of random gravities, then back to earth
    repeat (4) begin
      load_gravity(31'($urandom_range(1, 40 << FRAC_BITS)));
      queue_random(120);
      drain_and_settle();
    end
    load_gravity(31'($urandom));
    queue_random(60);
    drain_and_settle();
    load_gravity(GRAVITY_RESET);
    queue_random(100);
    drain_and_settle();

    $display("sent %0d words over nine gravity settings, checked %0d results",
             n_sent, n_checked);
    $display("%0d reachable, %0d unreachable, %0d field errors",
             n_hits, n_checked - n_hits, n_errors);
    if (n_errors == 0 && solves_due.size() == 0) begin
      $display("projectile_low_arc_solver: match");
    end else begin
      $display("projectile_low_arc_solver: mismatch");
    end
    $finish;
  end

endmodule
